### rtl/button_gesture_detector_assert.svh
// assertion macros for the button gesture detector
`ifndef BUTTON_GESTURE_DETECTOR_ASSERT_SVH
`define BUTTON_GESTURE_DETECTOR_ASSERT_SVH
`ifndef SYNTH
`define BGD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define BGD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BGD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define BGD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### rtl/bgd_pkg.sv
// shared types and constants for the button gesture detector
package bgd_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int OUT_W         = 32;
  localparam int MAX_EV        = 4;
  localparam int EV_IDX_W      = $clog2(MAX_EV);
  localparam int CNT_W         = $clog2(MAX_EV + 1);

  localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd800;
  localparam logic [CFG_W-1:0] DOUBLE_CLICK_RST = 16'd400;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_TIMER = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_LONG    = 3'd1,
    EV_RELEASE = 3'd2,
    EV_CLICK   = 3'd3,
    EV_DOUBLE  = 3'd4
  } evk_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_DOUBLE_CLICK = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] click_window;
  } cfg_t;

  typedef struct packed {
    evk_t             kind;
    logic [OUT_W-1:0] stamp;
    logic [OUT_W-1:0] held;
  } ev_t;

  typedef struct packed {
    logic [CNT_W-1:0]       n;
    ev_t  [MAX_EV-1:0]      ev;
  } batch_t;

endpackage

### rtl/bgd_cfg.sv
// configuration registers of the button gesture detector
module bgd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgd_pkg::CFG_W-1:0]     cfg_data,
  output bgd_pkg::cfg_t                cfg
);
  import bgd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time   <= DEBOUNCE_RST;
      cfg.long_press_time <= LONG_PRESS_RST;
      cfg.click_window    <= DOUBLE_CLICK_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE:     cfg.debounce_time   <= cfg_data;
        REG_LONG_PRESS:   cfg.long_press_time <= cfg_data;
        REG_DOUBLE_CLICK: cfg.click_window    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/bgd_core.sv
// input register, debounce and gesture state, event batch generation
`include "button_gesture_detector_assert.svh"
module bgd_core #(
  parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bgd_pkg::cfg_t            cfg,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               cmd,
  input  logic                     level_pressed,
  input  logic [bgd_pkg::OUT_W-1:0] stamp,
  input  logic                     can_load,
  output logic                     load,
  output bgd_pkg::batch_t          batch
);
  import bgd_pkg::*;

  typedef logic [TIME_BITS-1:0] tm_t;
  typedef logic [TIME_BITS:0]   tmx_t;

  typedef struct packed {
    logic started;
    logic stable;
    logic long_sent;
    tm_t  last_edge;
    logic press_valid;
    tm_t  press_time;
    logic click_valid;
    tm_t  click_rel;
    logic pend_valid;
    logic pend_level;
    tm_t  pend_time;
    tm_t  pend_deadline;
  } st_t;

  typedef struct packed {
    st_t    st;
    batch_t b;
  } commit_t;

  function automatic batch_t push(batch_t b_in, evk_t k, logic [OUT_W-1:0] t,
                                  logic [OUT_W-1:0] h);
    batch_t r;
    r = b_in;
    if (r.n < CNT_W'(MAX_EV)) begin
      r.ev[r.n[EV_IDX_W-1:0]].kind  = k;
      r.ev[r.n[EV_IDX_W-1:0]].stamp = t;
      r.ev[r.n[EV_IDX_W-1:0]].held  = h;
      r.n = r.n + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic logic reached(tm_t now, tm_t base, tm_t span);
    return (now >= base) && ((now - base) >= span);
  endfunction

  function automatic st_t init_level(st_t s_in, logic lvl, tm_t t);
    st_t s;
    s = s_in;
    s.started     = 1'b1;
    s.stable      = lvl;
    s.long_sent   = 1'b0;
    s.last_edge   = t;
    s.press_valid = 1'b0;
    s.click_valid = 1'b0;
    s.pend_valid  = 1'b0;
    return s;
  endfunction

  function automatic commit_t commit(st_t s_in, logic lvl, tm_t t, cfg_t c);
    commit_t r;
    tm_t     held;
    logic    long_now;
    logic    dbl;
    r.st     = s_in;
    r.b      = '0;
    held     = '0;
    long_now = 1'b0;
    dbl      = 1'b0;
    if (lvl != s_in.stable) begin
      r.st.last_edge = t;
      r.st.stable    = lvl;
      if (lvl) begin
        r.st.press_valid = 1'b1;
        r.st.press_time  = t;
        r.st.long_sent   = 1'b0;
        r.b = push(r.b, EV_PRESS, OUT_W'(t), '0);
      end else begin
        if (s_in.press_valid && (t >= s_in.press_time)) held = t - s_in.press_time;
        long_now = s_in.press_valid && !s_in.long_sent &&
                   (held >= tm_t'(c.long_press_time));
        if (long_now) begin
          r.b = push(r.b, EV_LONG, OUT_W'(s_in.press_time + tm_t'(c.long_press_time)),
                     OUT_W'(c.long_press_time));
        end
        r.b = push(r.b, EV_RELEASE, OUT_W'(t), OUT_W'(held));
        if (s_in.press_valid && !s_in.long_sent && !long_now) begin
          r.b = push(r.b, EV_CLICK, OUT_W'(t), OUT_W'(held));
          dbl = s_in.click_valid && ((t < s_in.click_rel) ||
                ((t - s_in.click_rel) <= tm_t'(c.click_window)));
          if (dbl) begin
            r.b = push(r.b, EV_DOUBLE, OUT_W'(t), OUT_W'(held));
            r.st.click_valid = 1'b0;
          end else begin
            r.st.click_valid = 1'b1;
            r.st.click_rel   = t;
          end
        end
        r.st.press_valid = 1'b0;
        r.st.long_sent   = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic commit_t due(st_t s_in, tm_t now, cfg_t c);
    commit_t r;
    st_t     s;
    s   = s_in;
    r.st = s_in;
    r.b  = '0;
    if (s_in.pend_valid && (now >= s_in.pend_deadline)) begin
      s.pend_valid = 1'b0;
      r = commit(s, s_in.pend_level, s_in.pend_time, c);
    end
    return r;
  endfunction

  function automatic batch_t merge(batch_t a_in, batch_t b_in);
    batch_t           r;
    logic [CNT_W:0]   sum;
    logic [CNT_W-1:0] j;
    r   = '0;
    sum = {1'b0, a_in.n} + {1'b0, b_in.n};
    r.n = (sum > (CNT_W+1)'(MAX_EV)) ? CNT_W'(MAX_EV) : sum[CNT_W-1:0];
    for (int i = 0; i < MAX_EV; i++) begin
      j = CNT_W'(i) - a_in.n;
      if (CNT_W'(i) < a_in.n) r.ev[i] = a_in.ev[i];
      else if (j < b_in.n)    r.ev[i] = b_in.ev[j[EV_IDX_W-1:0]];
    end
    return r;
  endfunction

  logic       in_full;
  logic [1:0] cmd_r;
  logic       lvl_r;
  tm_t        now_r;
  st_t        st;
  st_t        st_next;
  st_t        s;
  commit_t    a;
  commit_t    bres;
  tmx_t       dl;

  assign load     = in_full && can_load;
  assign in_stall = in_full && !can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r <= cmd;
      lvl_r <= level_pressed;
      now_r <= TIME_BITS'(stamp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.started     <= 1'b0;
      st.stable      <= 1'b0;
      st.long_sent   <= 1'b0;
      st.press_valid <= 1'b0;
      st.click_valid <= 1'b0;
      st.pend_valid  <= 1'b0;
      st.pend_level  <= 1'b0;
    end else if (load) begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    s       = st;
    a       = '0;
    a.st    = st;
    bres    = '0;
    dl      = '0;
    unique case (cmd_r)
      CMD_INIT: begin
        st_next = init_level(st, lvl_r, now_r);
      end
      CMD_EDGE: begin
        if (!st.started) begin
          st_next = init_level(st, lvl_r, now_r);
        end else begin
          a = due(st, now_r, cfg);
          s = a.st;
          if (lvl_r == s.stable) begin
            s.pend_valid = 1'b0;
          end else if ((now_r < s.last_edge) ||
                       ((now_r - s.last_edge) < tm_t'(cfg.debounce_time))) begin
            dl = {1'b0, s.last_edge} + tmx_t'(cfg.debounce_time);
            s.pend_valid    = 1'b1;
            s.pend_level    = lvl_r;
            s.pend_time     = now_r;
            s.pend_deadline = dl[TIME_BITS] ? '1 : dl[TIME_BITS-1:0];
          end else begin
            bres = commit(s, lvl_r, now_r, cfg);
            s    = bres.st;
          end
          st_next = s;
        end
      end
      CMD_TIMER: begin
        a = due(st, now_r, cfg);
        s = a.st;
        if (s.stable && s.press_valid && !s.long_sent &&
            reached(now_r, s.press_time, tm_t'(cfg.long_press_time))) begin
          s.long_sent = 1'b1;
          bres.b = push(bres.b, EV_LONG,
                        OUT_W'(s.press_time + tm_t'(cfg.long_press_time)),
                        OUT_W'(cfg.long_press_time));
        end
        if (s.click_valid &&
            reached(now_r, s.click_rel, tm_t'(cfg.click_window))) begin
          s.click_valid = 1'b0;
        end
        st_next = s;
      end
      default: ;
    endcase
    batch = merge(a.b, bres.b);
  end

  `BGD_ASSERT_IMPLY(a_core_pend_started, clk, rst, st.pend_valid, st.started, "pend before start")
  `BGD_ASSERT_IMPLY(a_core_press_stable, clk, rst, st.press_valid, st.stable, "press while released")
  `BGD_ASSERT_IMPLY(a_core_long_sent, clk, rst, st.long_sent, st.press_valid, "long without press")

endmodule

### rtl/bgd_evq.sv
// result register holding one batch of events, one beat per cycle unless out_stall holds it
`include "button_gesture_detector_assert.svh"
module bgd_evq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  bgd_pkg::batch_t           batch,
  output logic                      can_load,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [2:0]                event_kind,
  output logic [bgd_pkg::OUT_W-1:0] event_time,
  output logic [bgd_pkg::OUT_W-1:0] hold_time,
  output logic                      last
);
  import bgd_pkg::*;

  ev_t  [MAX_EV-1:0]   evs;
  logic [CNT_W-1:0]    n;
  logic [EV_IDX_W-1:0] pos;
  logic                busy;
  logic                at_last;
  logic                pop;
  logic                fill;

  assign at_last  = (CNT_W'(pos) == (n - CNT_W'(1)));
  assign pop      = busy && !out_stall;
  assign can_load = !busy || (pop && at_last);
  assign fill     = load && (batch.n != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (fill) begin
      busy <= 1'b1;
    end else if (pop && at_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fill) begin
      evs <= batch.ev;
      n   <= batch.n;
      pos <= '0;
    end else if (pop && !at_last) begin
      pos <= pos + EV_IDX_W'(1);
    end
  end

  assign out_valid  = busy;
  assign event_kind = evs[pos].kind;
  assign event_time = evs[pos].stamp;
  assign hold_time  = evs[pos].held;
  assign last       = at_last;

  `BGD_ASSERT_IMPLY(a_evq_load_free, clk, rst, fill, !busy || (pop && at_last), "load while busy")
  `BGD_ASSERT_IMPLY(a_evq_count, clk, rst, busy, (n != '0) && (n <= CNT_W'(MAX_EV)), "bad count")
  `BGD_ASSERT_NEXT(a_evq_drain, clk, rst, pop && at_last && !fill, !busy, "busy after last beat")

endmodule

### rtl/button_gesture_detector.sv
// top level of the button gesture detector
// An accepted item (init, raw edge or timer check) sits in the input register while earlier
// events still fill the result register; there the debounce and gesture state is updated
// and all of its events (up to four) are loaded into the result register; they then
// leave one beat per cycle unless out_stall holds them, the final one flagged by last.
// The result register draining its events sets the sustained rate; a new item is taken
// while the previous item's events are still being delivered. No clearing pass after
// reset.
module button_gesture_detector #(
  parameter int TIME_BITS = bgd_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    cmd,
  input  logic                          level_pressed,
  input  logic [bgd_pkg::OUT_W-1:0]     stamp,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    event_kind,
  output logic [bgd_pkg::OUT_W-1:0]     event_time,
  output logic [bgd_pkg::OUT_W-1:0]     hold_time,
  output logic                          last
);
  import bgd_pkg::*;

  cfg_t   cfg;
  batch_t batch;
  logic   load;
  logic   can_load;

  bgd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .cmd           (cmd),
    .level_pressed (level_pressed),
    .stamp         (stamp),
    .can_load      (can_load),
    .load          (load),
    .batch         (batch)
  );

  bgd_evq u_evq (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .batch      (batch),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .event_time (event_time),
    .hold_time  (hold_time),
    .last       (last)
  );

endmodule
